// ----- hdl/ffa_pkg.sv -----
package ffa_pkg;

	localparam int GW = 23;
	localparam int POOL_BYTES_DEF = 4194304;
	localparam int MAX_FREE_DEF = 64;
	localparam logic [3:0] SHIFT_RESET = 4'd6;
	localparam logic [3:0] SHIFT_MAX = 4'd8;

	typedef enum logic [1:0] {
		CMD_ALLOC   = 2'd0,
		CMD_FREE    = 2'd1,
		CMD_REALLOC = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOSPACE   = 3'd1,
		ST_BADHANDLE = 3'd2,
		ST_ZERO      = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0]    command;
		logic [GW-1:0] size_bytes;
		logic [GW-1:0] handle_offset;
		logic [GW-1:0] handle_size;
	} req_t;

	typedef struct packed {
		logic [2:0]    status;
		logic [GW-1:0] block_offset;
		logic [GW-1:0] block_size;
		logic          moved;
	} rsp_t;

	typedef struct packed {
		logic [GW-1:0] start;
		logic [GW-1:0] len;
	} entry_t;

endpackage

// ----- hdl/ffa_mem.sv -----
module ffa_mem
	import ffa_pkg::*;
#(
	parameter int DEPTH = MAX_FREE_DEF,
	parameter int AW = $clog2(MAX_FREE_DEF)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && waddr == raddr) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/ffa_ctrl.sv -----
module ffa_ctrl
	import ffa_pkg::*;
#(
	parameter int POOL_BYTES = POOL_BYTES_DEF,
	parameter int MAX_FREE_BLOCKS = MAX_FREE_DEF,
	parameter int AW = $clog2(MAX_FREE_DEF)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  req_t          request,
	output logic          busy,
	output logic          done,
	output rsp_t          result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output entry_t        mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  entry_t        mem_rdata
);

	localparam int CW = $clog2(MAX_FREE_BLOCKS + 1);
	localparam logic [GW:0] POOL_V = (GW+1)'(POOL_BYTES);
	localparam logic [CW-1:0] MAX_V = CW'(MAX_FREE_BLOCKS);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_SCAN = 7'b0000100,
		S_ACT  = 7'b0001000,
		S_SHDN = 7'b0010000,
		S_SHUP = 7'b0100000,
		S_RES  = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		P_ALLOC = 4'b0001,
		P_CHECK = 4'b0010,
		P_MFIT  = 4'b0100,
		P_MREL  = 4'b1000
	} phase_t;

	state_t        state_q;
	phase_t        ph_q;
	logic [3:0]    shift_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    cmd_q;
	logic [GW-1:0] need_q, hoff_q, hsz_q;
	logic          sfit_q;
	logic [CW-1:0] sidx_q, r_q, a_q, rem_q;
	logic          rv_s1;
	logic [AW-1:0] ri_s1, ins_idx_q, f_q;
	entry_t        prev_q, cur_q, ins_q, fitent_q;
	logic          rescan_q;
	logic          we_q;
	logic [AW-1:0] wa_q;
	entry_t        wd_q;
	rsp_t          rsp_q;
	logic          done_q;

	logic [GW:0]   pool_g, need_w, req_end, prev_end, h_end, rel_end;
	logic [GW-1:0] rel_off, rel_sz, extra, rel_rsz;
	logic          r_gt0, r_lt, left, right, bad, grow, rel_go, hit;

	always_comb begin
		pool_g = POOL_V >> shift_q;
		need_w = ({1'b0, request.size_bytes} + (((GW+1)'(1) << shift_q) - (GW+1)'(1)))
			>> shift_q;
		req_end = {1'b0, request.handle_offset} + {1'b0, request.handle_size};
		r_gt0 = r_q != '0;
		r_lt = r_q < cnt_q;
		prev_end = {1'b0, prev_q.start} + {1'b0, prev_q.len};
		h_end = {1'b0, hoff_q} + {1'b0, hsz_q};
		if (ph_q == P_CHECK && cmd_q == CMD_REALLOC) begin
			rel_off = hoff_q + need_q;
			rel_sz = hsz_q - need_q;
			rel_rsz = need_q;
		end else begin
			rel_off = hoff_q;
			rel_sz = hsz_q;
			rel_rsz = hsz_q;
		end
		rel_end = {1'b0, rel_off} + {1'b0, rel_sz};
		left = r_gt0 && prev_end == {1'b0, rel_off};
		right = r_lt && rel_end == {1'b0, cur_q.start};
		bad = (r_gt0 && prev_end > {1'b0, hoff_q}) || (r_lt && h_end > {1'b0, cur_q.start});
		extra = need_q - hsz_q;
		grow = r_lt && h_end == {1'b0, cur_q.start} && extra <= cur_q.len;
		rel_go = (ph_q == P_MREL) ||
			(ph_q == P_CHECK && !bad && (cmd_q == CMD_FREE || need_q < hsz_q));
		hit = sfit_q ? (mem_rdata.len >= need_q) : (mem_rdata.start > hoff_q);
	end

	assign busy = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE && !start;
	assign done = done_q;
	assign result = rsp_q;
	assign mem_we = we_q;
	assign mem_waddr = wa_q;
	assign mem_wdata = wd_q;
	assign mem_raddr = (state_q == S_SCAN) ? sidx_q[AW-1:0] : a_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			ph_q <= P_ALLOC;
			shift_q <= SHIFT_RESET;
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			we_q <= 1'b0;
			done_q <= 1'b0;
			rescan_q <= 1'b0;
		end else begin
			we_q <= 1'b0;
			done_q <= 1'b0;
			rv_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= request.command;
						need_q <= need_w[GW-1:0];
						hoff_q <= request.handle_offset;
						hsz_q <= request.handle_size;
						rescan_q <= 1'b0;
						sidx_q <= '0;
						rsp_q <= '0;
						state_q <= S_RES;
						if (request.command == CMD_ALLOC) begin
							if (request.size_bytes == '0) begin
								rsp_q.status <= ST_ZERO;
							end else begin
								sfit_q <= 1'b1;
								ph_q <= P_ALLOC;
								state_q <= S_SCAN;
							end
						end else if (request.command == CMD_FREE ||
							request.command == CMD_REALLOC) begin
							if (request.command == CMD_REALLOC && request.size_bytes == '0) begin
								rsp_q.status <= ST_ZERO;
							end else if (request.handle_size == '0 || req_end > pool_g) begin
								rsp_q.status <= ST_BADHANDLE;
							end else begin
								sfit_q <= 1'b0;
								ph_q <= P_CHECK;
								state_q <= S_SCAN;
							end
						end else begin
							rsp_q.status <= ST_BADHANDLE;
						end
					end else if (cfg_valid) begin
						shift_q <= (cfg_data > SHIFT_MAX) ? SHIFT_MAX : cfg_data;
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					we_q <= 1'b1;
					wa_q <= '0;
					wd_q.start <= '0;
					wd_q.len <= pool_g[GW-1:0];
					cnt_q <= CW'(1);
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (sidx_q < cnt_q) begin
						rv_s1 <= 1'b1;
						ri_s1 <= sidx_q[AW-1:0];
						sidx_q <= sidx_q + CW'(1);
					end
					if (rv_s1) begin
						if (hit) begin
							r_q <= CW'(ri_s1);
							cur_q <= mem_rdata;
							rv_s1 <= 1'b0;
							state_q <= S_ACT;
						end else begin
							prev_q <= mem_rdata;
						end
					end else if (sidx_q >= cnt_q) begin
						r_q <= cnt_q;
						state_q <= S_ACT;
					end
				end
				S_ACT: begin
					state_q <= S_RES;
					if (ph_q == P_ALLOC || ph_q == P_MFIT) begin
						if (!r_lt) begin
							rsp_q <= '0;
							rsp_q.status <= ST_NOSPACE;
						end else begin
							rsp_q.status <= ST_OK;
							rsp_q.block_offset <= cur_q.start;
							rsp_q.block_size <= need_q;
							rsp_q.moved <= ph_q == P_MFIT;
							f_q <= r_q[AW-1:0];
							fitent_q <= cur_q;
							rescan_q <= ph_q == P_MFIT;
							if (cur_q.len == need_q) begin
								a_q <= r_q + CW'(1);
								state_q <= S_SHDN;
							end else begin
								we_q <= 1'b1;
								wa_q <= r_q[AW-1:0];
								wd_q.start <= cur_q.start + need_q;
								wd_q.len <= cur_q.len - need_q;
								if (ph_q == P_MFIT) begin
									sfit_q <= 1'b0;
									sidx_q <= '0;
									ph_q <= P_MREL;
									state_q <= S_SCAN;
								end
							end
						end
					end else if (ph_q == P_CHECK && bad) begin
						rsp_q <= '0;
						rsp_q.status <= ST_BADHANDLE;
					end else if (rel_go) begin
						if (ph_q == P_CHECK) begin
							rsp_q.status <= ST_OK;
							rsp_q.block_offset <= hoff_q;
							rsp_q.block_size <= rel_rsz;
							rsp_q.moved <= 1'b0;
						end
						rescan_q <= 1'b0;
						if (left && right) begin
							we_q <= 1'b1;
							wa_q <= AW'(r_q - CW'(1));
							wd_q.start <= prev_q.start;
							wd_q.len <= prev_q.len + rel_sz + cur_q.len;
							a_q <= r_q + CW'(1);
							state_q <= S_SHDN;
						end else if (left) begin
							we_q <= 1'b1;
							wa_q <= AW'(r_q - CW'(1));
							wd_q.start <= prev_q.start;
							wd_q.len <= prev_q.len + rel_sz;
						end else if (right) begin
							we_q <= 1'b1;
							wa_q <= r_q[AW-1:0];
							wd_q.start <= rel_off;
							wd_q.len <= cur_q.len + rel_sz;
						end else if (cnt_q >= MAX_V) begin
							rsp_q <= '0;
							rsp_q.status <= ST_FULL;
							if (ph_q == P_MREL) begin
								we_q <= 1'b1;
								wa_q <= f_q;
								wd_q <= fitent_q;
							end
						end else begin
							a_q <= cnt_q - CW'(1);
							rem_q <= cnt_q - r_q;
							ins_idx_q <= r_q[AW-1:0];
							ins_q.start <= rel_off;
							ins_q.len <= rel_sz;
							state_q <= S_SHUP;
						end
					end else if (need_q == hsz_q) begin
						rsp_q.status <= ST_OK;
						rsp_q.block_offset <= hoff_q;
						rsp_q.block_size <= hsz_q;
						rsp_q.moved <= 1'b0;
					end else if (grow) begin
						rsp_q.status <= ST_OK;
						rsp_q.block_offset <= hoff_q;
						rsp_q.block_size <= need_q;
						rsp_q.moved <= 1'b0;
						rescan_q <= 1'b0;
						if (extra == cur_q.len) begin
							a_q <= r_q + CW'(1);
							state_q <= S_SHDN;
						end else begin
							we_q <= 1'b1;
							wa_q <= r_q[AW-1:0];
							wd_q.start <= cur_q.start + extra;
							wd_q.len <= cur_q.len - extra;
						end
					end else begin
						sfit_q <= 1'b1;
						sidx_q <= '0;
						ph_q <= P_MFIT;
						state_q <= S_SCAN;
					end
				end
				S_SHDN: begin
					if (a_q < cnt_q) begin
						rv_s1 <= 1'b1;
						ri_s1 <= a_q[AW-1:0];
						a_q <= a_q + CW'(1);
					end
					if (rv_s1) begin
						we_q <= 1'b1;
						wa_q <= ri_s1 - AW'(1);
						wd_q <= mem_rdata;
					end else if (a_q >= cnt_q) begin
						cnt_q <= cnt_q - CW'(1);
						if (rescan_q) begin
							sfit_q <= 1'b0;
							sidx_q <= '0;
							ph_q <= P_MREL;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RES;
						end
					end
				end
				S_SHUP: begin
					if (rem_q != '0) begin
						rv_s1 <= 1'b1;
						ri_s1 <= a_q[AW-1:0];
						a_q <= a_q - CW'(1);
						rem_q <= rem_q - CW'(1);
					end
					if (rv_s1) begin
						we_q <= 1'b1;
						wa_q <= ri_s1 + AW'(1);
						wd_q <= mem_rdata;
					end else if (rem_q == '0) begin
						we_q <= 1'b1;
						wa_q <= ins_idx_q;
						wd_q <= ins_q;
						cnt_q <= cnt_q + CW'(1);
						state_q <= S_RES;
					end
				end
				S_RES: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/first_fit_free_list_allocator.sv -----
// A request is taken when start is high and busy is low; its result appears
// on result for exactly one cycle with done high and cannot be held off, so
// the receiver must capture it then. A request takes up to five passes over
// the free table: a search that checks the handle, a first fit search, a
// search to release the old block of a moving reallocate, and two shifts of
// the table, one to drop a fully used entry and one to merge or insert the
// released block. Each pass moves one entry per cycle through the single
// read port of the table memory. After reset or a configuration write on
// cfg_data the table is reloaded, during which busy is high.
module first_fit_free_list_allocator
	import ffa_pkg::*;
#(
	parameter int POOL_BYTES = POOL_BYTES_DEF,
	parameter int MAX_FREE_BLOCKS = MAX_FREE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  req_t       request,
	output logic       busy,
	output logic       done,
	output rsp_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [3:0] cfg_data
);

	localparam int AW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	entry_t        mem_wdata, mem_rdata;

	ffa_mem #(
		.DEPTH(MAX_FREE_BLOCKS),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ffa_ctrl #(
		.POOL_BYTES(POOL_BYTES),
		.MAX_FREE_BLOCKS(MAX_FREE_BLOCKS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.request(request),
		.busy(busy),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |->
		result.block_size == '0 && result.block_offset == '0 && !result.moved)
		else $error("error result carries a block");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.status <= ST_FULL)
		else $error("status code out of range");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !busy && !start)
		else $error("config ready while work pending");

endmodule

// ----- tb/sv/tb_first_fit_free_list_allocator.sv -----
module tb_first_fit_free_list_allocator;
	import ffa_pkg::*;

	localparam int POOL = 4194304;
	localparam int NFREE = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy, done;
	rsp_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [3:0] cfg_data = '0;

	first_fit_free_list_allocator uut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// allocator mirror
	int unsigned gran_shift;
	int unsigned fs [NFREE];
	int unsigned fl [NFREE];
	int unsigned fn;

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int errors = 0;
	int mismatches = 0;
	int gap = 0;
	logic cfg_pending = 1'b0;
	logic [3:0] cfg_next = '0;

	// live blocks handed out, used to build legal frees and reallocs
	int unsigned live_off[$];
	int unsigned live_sz[$];

	function automatic int unsigned pool_gran();
		return POOL >> gran_shift;
	endfunction

	function automatic void table_init(logic [3:0] v);
		gran_shift = (v > SHIFT_MAX) ? SHIFT_MAX : v;
		for (int i = 0; i < NFREE; i++) begin
			fs[i] = 0;
			fl[i] = 0;
		end
		fl[0] = pool_gran();
		fn = 1;
	endfunction

	function automatic int unsigned first_above(int unsigned off);
		int unsigned i;
		i = 0;
		while (i < fn && fs[i] <= off) i++;
		return i;
	endfunction

	function automatic void drop_entry(int unsigned i);
		for (int unsigned k = i; k + 1 < fn; k++) begin
			fs[k] = fs[k+1];
			fl[k] = fl[k+1];
		end
		fn--;
	endfunction

	function automatic void add_entry(int unsigned i, int unsigned s, int unsigned l);
		for (int unsigned k = fn; k > i; k--) begin
			fs[k] = fs[k-1];
			fl[k] = fl[k-1];
		end
		fs[i] = s;
		fl[i] = l;
		fn++;
	endfunction

	function automatic bit handle_invalid(int unsigned off, int unsigned sz);
		int unsigned r;
		if (sz == 0 || off + sz > pool_gran()) return 1;
		r = first_above(off);
		if (r > 0 && fs[r-1] + fl[r-1] > off) return 1;
		if (r < fn && off + sz > fs[r]) return 1;
		return 0;
	endfunction

	function automatic status_t give_back(int unsigned off, int unsigned sz);
		int unsigned r;
		bit lm, rm;
		r = first_above(off);
		lm = r > 0 && fs[r-1] + fl[r-1] == off;
		rm = r < fn && off + sz == fs[r];
		if (lm && rm) begin
			fl[r-1] += sz + fl[r];
			drop_entry(r);
		end else if (lm) begin
			fl[r-1] += sz;
		end else if (rm) begin
			fs[r] = off;
			fl[r] += sz;
		end else begin
			if (fn >= NFREE) return ST_FULL;
			add_entry(r, off, sz);
		end
		return ST_OK;
	endfunction

	function automatic status_t carve_first_fit(int unsigned need, output int unsigned off);
		off = 0;
		for (int unsigned i = 0; i < fn; i++) begin
			if (fl[i] >= need) begin
				off = fs[i];
				if (fl[i] == need) drop_entry(i);
				else begin
					fs[i] += need;
					fl[i] -= need;
				end
				return ST_OK;
			end
		end
		return ST_NOSPACE;
	endfunction

	function automatic rsp_t predict_alloc(req_t rq);
		int unsigned bytes, hoff, hsz, need, roff, rsz, extra, r, sn;
		int unsigned ss [NFREE];
		int unsigned sl [NFREE];
		status_t st;
		bit mv;
		rsp_t o;
		bytes = rq.size_bytes;
		hoff = rq.handle_offset;
		hsz = rq.handle_size;
		need = (bytes + (1 << gran_shift) - 1) >> gran_shift;
		roff = 0;
		rsz = 0;
		mv = 0;
		st = ST_OK;
		case (rq.command)
			CMD_ALLOC: begin
				if (bytes == 0) st = ST_ZERO;
				else begin
					st = carve_first_fit(need, roff);
					rsz = need;
				end
			end
			CMD_FREE: begin
				if (handle_invalid(hoff, hsz)) st = ST_BADHANDLE;
				else begin
					st = give_back(hoff, hsz);
					roff = hoff;
					rsz = hsz;
				end
			end
			CMD_REALLOC: begin
				if (bytes == 0) st = ST_ZERO;
				else if (handle_invalid(hoff, hsz)) st = ST_BADHANDLE;
				else if (need == hsz) begin
					roff = hoff;
					rsz = hsz;
				end else if (need < hsz) begin
					st = give_back(hoff + need, hsz - need);
					roff = hoff;
					rsz = need;
				end else begin
					extra = need - hsz;
					r = first_above(hoff);
					roff = hoff;
					rsz = need;
					if (r < fn && hoff + hsz == fs[r] && extra <= fl[r]) begin
						if (extra == fl[r]) drop_entry(r);
						else begin
							fs[r] += extra;
							fl[r] -= extra;
						end
					end else begin
						ss = fs;
						sl = fl;
						sn = fn;
						st = carve_first_fit(need, roff);
						if (st == ST_OK) st = give_back(hoff, hsz);
						if (st != ST_OK) begin
							fs = ss;
							fl = sl;
							fn = sn;
						end else mv = 1;
					end
				end
			end
			default: st = ST_BADHANDLE;
		endcase
		if (st != ST_OK) begin
			roff = 0;
			rsz = 0;
			mv = 0;
		end
		o.status = st;
		o.block_offset = roff[GW-1:0];
		o.block_size = rsz[GW-1:0];
		o.moved = mv;
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				start <= 1'b0;
				gap <= $urandom_range(0, 7);
			end else if (!start && pending_reqs.size() > 0) begin
				if (gap > 0) gap <= gap - 1;
				else begin
					request <= pending_reqs[0];
					expected_rsps.push_back(predict_alloc(pending_reqs.pop_front()));
					start <= 1'b1;
				end
			end
			if (cfg_valid && cfg_ready) cfg_valid <= 1'b0;
			else if (cfg_pending && !cfg_valid) begin
				cfg_data <= cfg_next;
				cfg_valid <= 1'b1;
				cfg_pending <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && done) begin
			if (expected_rsps.size() == 0) begin
				errors++;
				if (mismatches < 10) $display("unexpected result %p", result);
				mismatches++;
			end else begin
				e = expected_rsps.pop_front();
				if (result !== e) begin
					errors++;
					if (mismatches < 10) $display("mismatch exp %p act %p", e, result);
					mismatches++;
				end
			end
		end
	end

	task automatic push_req(logic [1:0] c, int unsigned b, int unsigned o, int unsigned s);
		req_t rq;
		rq.command = c;
		rq.size_bytes = b[GW-1:0];
		rq.handle_offset = o[GW-1:0];
		rq.handle_size = s[GW-1:0];
		pending_reqs.push_back(rq);
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (3 * NFREE + 20) @(posedge clk);
	endtask

	task automatic set_shift(logic [3:0] v);
		cfg_next = v;
		cfg_pending = 1'b1;
		@(posedge clk);
		while (cfg_pending || cfg_valid) @(posedge clk);
		table_init(v);
		live_off.delete();
		live_sz.delete();
		repeat (4) @(posedge clk);
	endtask

	// random phase: a mirror of live blocks keeps most frees and reallocs legal
	task automatic random_phase(int n);
		int unsigned k, b, o, s, sel, p;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			p = pool_gran();
			if (sel < 40 || live_off.size() == 0) begin
				b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8388607)
					: $urandom_range(1, 1 << ($urandom_range(0, 16)));
				push_req(CMD_ALLOC, b, $urandom, $urandom);
			end else if (sel < 70) begin
				k = $urandom_range(0, live_off.size() - 1);
				push_req(CMD_FREE, $urandom, live_off[k], live_sz[k]);
			end else if (sel < 90) begin
				k = $urandom_range(0, live_off.size() - 1);
				b = $urandom_range(1, live_sz[k] << gran_shift) +
					$urandom_range(0, 3) * $urandom_range(0, 1 << 14);
				push_req(CMD_REALLOC, b, live_off[k], live_sz[k]);
			end else begin
				o = ($urandom_range(0, 1)) ? $urandom_range(0, p) : $urandom_range(0, 8388607);
				s = ($urandom_range(0, 1)) ? $urandom_range(0, 64) : $urandom_range(0, 8388607);
				push_req(2'($urandom_range(0, 3)), $urandom_range(0, 8388607), o, s);
			end
			track_last();
		end
	endtask

	// replay the queued request on a scratch mirror to learn the resulting block
	task automatic track_last();
		int unsigned ss [NFREE];
		int unsigned sl [NFREE];
		int unsigned sn, k;
		req_t rq;
		rsp_t r;
		ss = fs;
		sl = fl;
		sn = fn;
		rq = pending_reqs[pending_reqs.size() - 1];
		r = predict_alloc(rq);
		fs = ss;
		fl = sl;
		fn = sn;
		if (r.status != ST_OK) return;
		void'(predict_alloc(rq));
		fs = ss;
		fl = sl;
		fn = sn;
		if (rq.command == CMD_FREE || rq.command == CMD_REALLOC) begin
			for (k = 0; k < live_off.size(); k++)
				if (live_off[k] == rq.handle_offset && live_sz[k] == rq.handle_size) break;
			if (k < live_off.size()) begin
				live_off.delete(k);
				live_sz.delete(k);
			end
		end
		if (rq.command != CMD_FREE) begin
			live_off.push_back(r.block_offset);
			live_sz.push_back(r.block_size);
		end
		// advance the planning mirror; the driver re-predicts from its own copy
		void'(predict_alloc(rq));
	endtask

	// the planning mirror runs ahead of the driver, so each phase is
	// planned with the mirror saved and restored before the driver consumes it
	task automatic run_phase(int n);
		int unsigned ss [NFREE];
		int unsigned sl [NFREE];
		int unsigned sn;
		ss = fs;
		sl = fl;
		sn = fn;
		random_phase(n);
		fs = ss;
		fl = sl;
		fn = sn;
		drain();
	endtask

	initial begin
		table_init(SHIFT_RESET);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		// directed
		push_req(CMD_ALLOC, 0, 0, 0);
		push_req(CMD_ALLOC, 1, 0, 0);
		push_req(CMD_ALLOC, 64, 0, 0);
		push_req(CMD_ALLOC, 65, 0, 0);
		push_req(CMD_FREE, 0, 0, 1);
		push_req(CMD_FREE, 0, 0, 1);
		push_req(CMD_FREE, 0, 1, 0);
		push_req(CMD_FREE, 0, 65535, 2);
		push_req(CMD_REALLOC, 0, 1, 2);
		push_req(CMD_REALLOC, 128, 1, 2);
		push_req(CMD_REALLOC, 64, 1, 2);
		push_req(CMD_REALLOC, 1000, 1, 1);
		push_req(2'd3, 8388607, 8388607, 8388607);
		push_req(CMD_ALLOC, 8388607, 0, 0);
		push_req(CMD_ALLOC, 4194304, 0, 0);
		push_req(CMD_FREE, 0, 0, 65536);
		push_req(CMD_ALLOC, 4194304, 0, 0);
		push_req(CMD_REALLOC, 8388607, 0, 65536);
		push_req(CMD_FREE, 0, 0, 65536);
		drain();
		for (int i = 0; i < 70; i++) push_req(CMD_ALLOC, 64, 0, 0);
		for (int i = 0; i < 70; i += 2) push_req(CMD_FREE, 0, i, 1);
		push_req(CMD_REALLOC, 64, 1, 1);
		drain();
		set_shift(4'd0);
		run_phase(175);
		set_shift(4'd15);
		run_phase(175);
		set_shift(4'd8);
		run_phase(125);
		set_shift(4'd3);
		run_phase(125);
		set_shift(SHIFT_RESET);
		run_phase(125);
		if (errors == 0) $display("first_fit_free_list_allocator regression: pass");
		else $display("first_fit_free_list_allocator regression: fail");
		$finish;
	end

	initial begin
		#20000000;
		$display("first_fit_free_list_allocator regression: fail");
		$finish;
	end

endmodule
